[rtl/core/slsr_pkg.sv]
// slsr_pkg: shared types and constants for the stepper linear speed ramp unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package slsr_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_SPEED = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    PH_STOP  = 2'd0,
    PH_ACCEL = 2'd1,
    PH_RUN   = 2'd2,
    PH_DECEL = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    CFG_TIME_SCALE  = 2'd0,
    CFG_FREQ_SCALE  = 2'd1,
    CFG_ACCEL_SCALE = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MINDIV,
    ST_ACCDIV,
    ST_SQRT,
    ST_MUL,
    ST_DIV100,
    ST_SPDFIN,
    ST_TICKPRE,
    ST_TICKDIV,
    ST_TICKFIN,
    ST_OUT
  } state_e;

  // divider operand selection
  typedef enum logic [1:0] {
    DSRC_MIN,
    DSRC_ACC,
    DSRC_TICK
  } dsrc_e;

  typedef struct packed {
    logic    latch_in;
    logic    div_start;
    dsrc_e   div_src;
    logic    sqrt_start;
    logic    mul_do;
    logic    div100_do;
    logic    spd_fin;
    logic    tick_pre;
    logic    tick_fin;
    logic    other_fin;
  } ctl_t;

  typedef struct packed {
    logic   div_busy;
    logic   sqrt_busy;
    logic   was_stop;
    logic   zero_acc;
    cmd_e   cmd;
    phase_e phase;
  } sts_t;

  localparam int unsigned DivW   = 64;
  localparam int unsigned IdxMax = 32767;
  localparam int unsigned RootW  = 32;

  // floor(x / 100) = (x * Recip100) >> Recip100Shift for any 32-bit x
  localparam logic [63:0] Recip100      = 64'h0000_0000_51EB_851F;
  localparam int unsigned Recip100Shift = 37;

endpackage
`default_nettype wire

[rtl/core/slsr_dp.sv]
// slsr_dp: datapath of the ramp unit, shared restoring divider,
// bit-pair square root, reciprocal divide by 100, ramp state registers; uses slsr_pkg
`timescale 1ns / 1ps
`default_nettype none
module slsr_dp #(
  parameter int unsigned PERIOD_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire slsr_pkg::ctl_t         ctl_i,
  output slsr_pkg::sts_t              sts_o,
  input  wire logic [1:0]             cmd_i,
  input  wire logic [15:0]            speed_i,
  input  wire logic [15:0]            accel_i,
  input  wire logic [31:0]            time_scale_i,
  input  wire logic [15:0]            freq_scale_i,
  input  wire logic [31:0]            accel_scale_i,
  output logic                        step_o,
  output logic [PERIOD_BITS-1:0]      period_o,
  output logic                        running_o,
  output logic [1:0]                  phase_o
);
  import slsr_pkg::*;

  localparam logic [PERIOD_BITS-1:0] PMax = {PERIOD_BITS{1'b1}};
  // 2 * period + remainder, remainder up to 16 bits
  localparam int unsigned NumW = PERIOD_BITS + 18;

  logic [1:0]  cmd_q;
  logic [15:0] spd_q, acc_q;
  phase_e      ph_q;
  logic [PERIOD_BITS-1:0] per_q, minp_q, shown_q;
  logic [15:0] idx_q, rem_q;
  logic        drv_q, step_q, was_stop_q;

  // divider: 64-bit dividend, 33-bit divisor, one bit per cycle
  logic [63:0] dvd_q;
  logic [32:0] dvr_q;
  logic [32:0] prem_q;
  logic [6:0]  dcnt_q;
  logic        dbusy_q;

  // square root
  logic [31:0] srest_q, sroot_q, sbit_q;
  logic        sbusy_q;

  // freq_scale * root always fits 32 bits
  logic [31:0] prod_q;
  logic [26:0] q100_q;
  logic [63:0] recip_w;

  // tick terms
  logic signed [15:0] nidx_q;
  logic [NumW-1:0]    num_q;
  logic [17:0]        mag_q;
  logic               dpos_q;

  logic [63:0] dvd_src;
  logic [32:0] dvr_src;
  always_comb begin
    unique case (ctl_i.div_src)
      DSRC_MIN: begin
        dvd_src = {32'd0, time_scale_i};
        dvr_src = {17'd0, spd_q};
      end
      DSRC_ACC: begin
        dvd_src = {32'd0, accel_scale_i};
        dvr_src = {17'd0, acc_q};
      end
      default: begin
        dvd_src = {{(64-NumW){1'b0}}, num_q};
        dvr_src = {15'd0, mag_q};
      end
    endcase
  end

  logic [33:0] trial;
  assign trial = {prem_q, dvd_q[63]} - {1'b0, dvr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      dcnt_q  <= '0;
    end else if (ctl_i.div_start) begin
      dbusy_q <= 1'b1;
      dcnt_q  <= 7'd64;
    end else if (dbusy_q) begin
      dcnt_q <= dcnt_q - 7'd1;
      if (dcnt_q == 7'd1) dbusy_q <= 1'b0;
    end
  end

  // quotient bits shift into dvd_q
  always_ff @(posedge clk_i) begin
    if (ctl_i.div_start) begin
      dvd_q  <= dvd_src;
      dvr_q  <= dvr_src;
      prem_q <= '0;
    end else if (dbusy_q) begin
      if (!trial[33]) begin
        prem_q <= trial[32:0];
        dvd_q  <= {dvd_q[62:0], 1'b1};
      end else begin
        prem_q <= {prem_q[31:0], dvd_q[63]};
        dvd_q  <= {dvd_q[62:0], 1'b0};
      end
    end
  end

  // square root, two bits per cycle
  logic [32:0] s_sum;
  assign s_sum = {1'b0, sroot_q} + {1'b0, sbit_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sbusy_q <= 1'b0;
    else if (ctl_i.sqrt_start) sbusy_q <= 1'b1;
    else if (sbusy_q && sbit_q[1:0] != 2'd0) sbusy_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (ctl_i.sqrt_start) begin
      srest_q <= dvd_q[31:0];
      sroot_q <= '0;
      sbit_q  <= 32'h4000_0000;
    end else if (sbusy_q) begin
      if (s_sum <= {1'b0, srest_q}) begin
        srest_q <= srest_q - s_sum[31:0];
        sroot_q <= (sroot_q >> 1) + sbit_q;
      end else begin
        sroot_q <= sroot_q >> 1;
      end
      sbit_q <= sbit_q >> 2;
    end
  end

  logic [31:0] rsqrt;
  assign rsqrt = (sroot_q < srest_q) ? sroot_q + 32'd1 : sroot_q;

  // divide by 100 as a multiply by the reciprocal
  assign recip_w = {32'd0, prod_q} * Recip100;

  function automatic logic [PERIOD_BITS-1:0] sat(input logic [63:0] v);
    if (v > {{(64-PERIOD_BITS){1'b0}}, PMax}) return PMax;
    return v[PERIOD_BITS-1:0];
  endfunction

  // tick pre-computation from the stored state
  logic signed [15:0] n_inc;
  logic signed [17:0] d_s;
  always_comb begin
    n_inc = (idx_q == 16'(IdxMax)) ? $signed(idx_q) : $signed(idx_q + 16'd1);
    d_s   = 18'($signed(n_inc)) * 18'sd4 + 18'sd1;
  end

  logic [63:0] q_w;
  logic [PERIOD_BITS:0] np_w;
  logic [PERIOD_BITS-1:0] np_sat, minp_nx, fp_nx;
  always_comb begin
    q_w = dvd_q;
    if (dpos_q)
      np_w = (q_w > {{(64-PERIOD_BITS){1'b0}}, per_q}) ? '0
           : {1'b0, per_q} - q_w[PERIOD_BITS:0];
    else if (q_w > {{(64-PERIOD_BITS){1'b0}}, PMax})
      np_w = {1'b0, PMax};
    else
      np_w = {1'b0, per_q} + q_w[PERIOD_BITS:0];
    np_sat = np_w[PERIOD_BITS] ? PMax : np_w[PERIOD_BITS-1:0];
  end

  // first period only when the command came in the stop phase
  always_comb begin
    fp_nx = per_q;
    if (was_stop_q) fp_nx = (acc_q == 16'd0) ? PMax : sat({37'd0, q100_q});
    minp_nx = minp_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_STOP;
      per_q  <= '0;
      minp_q <= '0;
      idx_q  <= '0;
      rem_q  <= '0;
      drv_q  <= 1'b0;
      step_q <= 1'b0;
      shown_q <= '0;
      was_stop_q <= 1'b0;
    end else begin
      if (ctl_i.latch_in) begin
        was_stop_q <= (ph_q == PH_STOP);
        shown_q    <= per_q;
      end
      if (ctl_i.div_start && ctl_i.div_src == DSRC_ACC) begin
        minp_q <= (spd_q == 16'd0) ? PMax : sat(dvd_q);
      end
      if (ctl_i.spd_fin) begin
        if (fp_nx <= minp_nx) begin
          per_q <= minp_nx;
          ph_q  <= PH_RUN;
        end else begin
          per_q <= fp_nx;
          ph_q  <= PH_ACCEL;
        end
        idx_q   <= '0;
        drv_q   <= 1'b1;
        step_q  <= 1'b0;
        shown_q <= (fp_nx <= minp_nx) ? minp_nx : fp_nx;
      end
      if (ctl_i.tick_pre) begin
        idx_q <= n_inc;
      end
      if (ctl_i.tick_fin) begin
        step_q <= 1'b1;
        if (ph_q == PH_ACCEL && np_sat <= minp_q) begin
          per_q <= minp_q;
          rem_q <= '0;
          ph_q  <= PH_RUN;
        end else begin
          per_q <= np_sat;
          rem_q <= (prem_q > 33'h0FFFF) ? 16'hFFFF : prem_q[15:0];
          if (ph_q != PH_ACCEL && !idx_q[15]) ph_q <= PH_STOP;
        end
      end
      if (ctl_i.other_fin) begin
        if (cmd_q == CMD_TICK) begin
          if (ph_q == PH_RUN) begin
            per_q  <= minp_q;
            step_q <= 1'b1;
          end else begin
            step_q <= 1'b0;
            rem_q  <= '0;
            drv_q  <= 1'b0;
          end
        end else begin
          step_q  <= 1'b0;
          shown_q <= per_q;
          if (cmd_q == CMD_STOP && (ph_q == PH_ACCEL || ph_q == PH_RUN)) begin
            idx_q <= 16'd0 - idx_q;
            ph_q  <= PH_DECEL;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch_in) begin
      cmd_q <= cmd_i;
      spd_q <= speed_i;
      acc_q <= accel_i;
    end
    if (ctl_i.mul_do) prod_q <= 32'(freq_scale_i) * rsqrt;
    if (ctl_i.div100_do) q100_q <= recip_w[63:Recip100Shift];
    if (ctl_i.tick_pre) begin
      nidx_q <= n_inc;
      dpos_q <= !d_s[17];
      mag_q  <= d_s[17] ? 18'(-d_s) : 18'(d_s);
      num_q  <= NumW'({per_q, 1'b0}) + NumW'(rem_q);
    end
  end

  assign sts_o = '{div_busy: dbusy_q, sqrt_busy: sbusy_q, was_stop: was_stop_q,
                   zero_acc: (acc_q == 16'd0), cmd: cmd_e'(cmd_q), phase: ph_q};

  assign step_o    = step_q;
  assign period_o  = shown_q;
  assign running_o = drv_q;
  assign phase_o   = ph_q;

  logic unused_n;
  assign unused_n = ^nidx_q;
endmodule
`default_nettype wire

[rtl/core/slsr_ctrl.sv]
// slsr_ctrl: sequencer of the ramp unit, issues datapath commands
// and runs the input and output handshakes; uses slsr_pkg
`timescale 1ns / 1ps
`default_nettype none
module slsr_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire logic [1:0]      cmd_i,
  input  wire slsr_pkg::sts_t  sts_i,
  output slsr_pkg::ctl_t       ctl_o
);
  import slsr_pkg::*;

  state_e st_q, st_d;
  logic   wait_q, wait_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      wait_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      wait_q <= wait_d;
    end
  end

  logic acc_in;
  assign acc_in = in_valid_i && in_ready_o;

  always_comb begin
    st_d   = st_q;
    wait_d = 1'b0;
    unique case (st_q)
      ST_IDLE: if (acc_in) begin
        unique case (cmd_e'(cmd_i))
          CMD_SPEED: begin st_d = ST_MINDIV; wait_d = 1'b1; end
          CMD_TICK:  st_d = ST_TICKPRE;
          default:   st_d = ST_SPDFIN;
        endcase
      end
      ST_MINDIV:  if (!wait_q && !sts_i.div_busy) begin
        st_d = ST_ACCDIV;
        wait_d = 1'b1;
      end
      ST_ACCDIV:  if (!wait_q && !sts_i.div_busy) begin
        st_d = sts_i.was_stop ? ST_SQRT : ST_SPDFIN;
        wait_d = 1'b1;
      end else wait_d = 1'b0;
      ST_SQRT:    begin
        if (!wait_q && !sts_i.div_busy && !sts_i.sqrt_busy && wait_d == 1'b0)
          st_d = ST_MUL;
      end
      ST_MUL:     st_d = ST_DIV100;
      ST_DIV100:  st_d = ST_SPDFIN;
      ST_SPDFIN:  st_d = ST_OUT;
      ST_TICKPRE: begin
        st_d = (sts_i.phase == PH_ACCEL || sts_i.phase == PH_DECEL) ?
               ST_TICKDIV : ST_SPDFIN;
        wait_d = 1'b1;
      end
      ST_TICKDIV: if (!wait_q && !sts_i.div_busy) st_d = ST_TICKFIN;
      ST_TICKFIN: st_d = ST_OUT;
      ST_OUT:     if (out_ready_i) st_d = ST_IDLE;
      default:    st_d = ST_IDLE;
    endcase
  end

  logic sqrt_go_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sqrt_go_q <= 1'b0;
    else sqrt_go_q <= (st_q == ST_ACCDIV) && (st_d == ST_SQRT);
  end

  always_comb begin
    ctl_o        = '0;
    ctl_o.div_src = DSRC_MIN;
    in_ready_o   = (st_q == ST_IDLE);
    out_valid_o  = (st_q == ST_OUT);
    ctl_o.latch_in = acc_in;
    unique case (st_q)
      ST_MINDIV: if (wait_q) begin
        ctl_o.div_start = 1'b1; ctl_o.div_src = DSRC_MIN;
      end
      ST_ACCDIV: if (wait_q) begin
        ctl_o.div_start = 1'b1; ctl_o.div_src = DSRC_ACC;
      end
      ST_SQRT:   ctl_o.sqrt_start = sqrt_go_q;
      ST_MUL:    ctl_o.mul_do = 1'b1;
      ST_DIV100: ctl_o.div100_do = 1'b1;
      ST_SPDFIN: begin
        if (sts_i.cmd == CMD_SPEED) ctl_o.spd_fin = 1'b1;
        else ctl_o.other_fin = 1'b1;
      end
      ST_TICKPRE: ctl_o.tick_pre = (sts_i.phase == PH_ACCEL ||
                                    sts_i.phase == PH_DECEL);
      ST_TICKDIV: if (wait_q) begin
        ctl_o.div_start = 1'b1; ctl_o.div_src = DSRC_TICK;
      end
      ST_TICKFIN: ctl_o.tick_fin = 1'b1;
      default: ;
    endcase
  end

  logic unused_z;
  assign unused_z = sts_i.zero_acc;
endmodule
`default_nettype wire

[rtl/core/stepper_linear_speed_ramp_unit.sv]
// stepper_linear_speed_ramp_unit: top level of the step-delay generator
// instantiates slsr_ctrl and slsr_dp, uses slsr_pkg
//
// channel | direction | content
// s_axis  | in        | tuser: command[1:0]; tdata: speed[15:0], acceleration[31:16]
// m_axis  | out       | tdata: step[0], period_out, running, phase
// cfg     | in        | index 0 time_scale, 1 freq_scale, 2 accel_scale
//
// one transaction at a time; the 64-step shared divider and the root unit set its length:
// a tick in accelerate or decelerate uses one division, set speed uses two divisions
// and the root from stop and two divisions otherwise; stop, unused commands and
// ticks in run or stop use neither
// reset clears the ramp state and loads the register defaults
// a stalled result holds the unit; no new item is taken until it leaves
`timescale 1ns / 1ps
`default_nettype none
module stepper_linear_speed_ramp_unit #(
  parameter int unsigned PERIOD_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // speed, acceleration
  input  wire logic [1:0]  s_axis_tuser,   // command
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [((PERIOD_BITS+4+7)/8)*8-1:0] m_axis_tdata, // step, period_out, running, phase
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  import slsr_pkg::*;

  localparam int unsigned OutW = ((PERIOD_BITS + 4 + 7) / 8) * 8;

  logic [31:0] time_scale_q, accel_scale_q;
  logic [15:0] freq_scale_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_scale_q  <= 32'd785398;
      freq_scale_q  <= 16'd1690;
      accel_scale_q <= 32'd628318530;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TIME_SCALE:  time_scale_q  <= cfg_data_i;
        CFG_FREQ_SCALE:  freq_scale_q  <= cfg_data_i[15:0];
        CFG_ACCEL_SCALE: accel_scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ctl_t ctl;
  sts_t sts;
  logic step;
  logic [PERIOD_BITS-1:0] per;
  logic run;
  logic [1:0] ph;

  slsr_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_i      (s_axis_tuser),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  slsr_dp #(.PERIOD_BITS(PERIOD_BITS)) u_dp (
    .clk_i, .rst_ni,
    .ctl_i        (ctl),
    .sts_o        (sts),
    .cmd_i        (s_axis_tuser),
    .speed_i      (s_axis_tdata[15:0]),
    .accel_i      (s_axis_tdata[31:16]),
    .time_scale_i (time_scale_q),
    .freq_scale_i (freq_scale_q),
    .accel_scale_i(accel_scale_q),
    .step_o       (step),
    .period_o     (per),
    .running_o    (run),
    .phase_o      (ph)
  );

  assign m_axis_tdata = OutW'({ph, run, per, step});
endmodule
`default_nettype wire

[tb/tb_stepper_linear_speed_ramp_unit.sv]
// tb_stepper_linear_speed_ramp_unit: self-checking bench for the step-delay generator
// drives commands over the input stream, predicts each result and checks the output stream
// depends on slsr_pkg and stepper_linear_speed_ramp_unit
`timescale 1ns / 1ps
module tb_stepper_linear_speed_ramp_unit;
  import slsr_pkg::*;

  localparam int PB = 16;
  localparam int OW = ((PB + 4 + 7) / 8) * 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OW-1:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  always #1 clk_i = ~clk_i;

  stepper_linear_speed_ramp_unit #(.PERIOD_BITS(PB)) dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // packed from the lowest bit up: step, period, running, phase
  typedef struct packed {
    phase_e        phase;
    logic          running;
    logic [PB-1:0] period;
    logic          step;
  } ramp_out_t;

  // predicted copy of the registers and ramp state
  logic [31:0] m_time_scale, m_accel_scale;
  logic [15:0] m_freq_scale;
  phase_e      m_phase;
  logic [PB-1:0] m_period, m_min_period;
  logic [15:0] m_index, m_rem;
  logic        m_drive;

  ramp_out_t pending_results[$];
  int errors = 0;
  int send_idle = 0;   // percent
  int recv_stall = 0;  // percent

  localparam logic [63:0] PMAX = (64'd1 << PB) - 1;

  function automatic logic [PB-1:0] clamp_period(logic [63:0] v);
    return (v > PMAX) ? PMAX[PB-1:0] : v[PB-1:0];
  endfunction

  // square root by bit pairs, rounded up when the leftover exceeds the root
  function automatic logic [63:0] root_rounded(logic [31:0] x);
    logic [63:0] rest, root, bitv;
    logic take;
    rest = x; root = 0; bitv = 64'h4000_0000;
    while (bitv != 0) begin
      take = (root + bitv) <= rest;
      if (take) rest = rest - (root + bitv);
      root = root >> 1;
      if (take) root = root + bitv;
      bitv = bitv >> 2;
    end
    return (root < rest) ? root + 1 : root;
  endfunction

  // one step of the period recurrence with the current index
  function automatic logic [PB-1:0] recur_period();
    longint n, d, mag, num, q, r, np;
    n = longint'($signed(m_index));
    d = 4 * n + 1;
    mag = d < 0 ? -d : d;
    num = 2 * longint'(m_period) + longint'(m_rem);
    q = num / mag;
    r = num % mag;
    m_rem = (r > 65535) ? 16'hFFFF : r[15:0];
    if (d > 0) np = (q > longint'(m_period)) ? 0 : longint'(m_period) - q;
    else np = longint'(m_period) + q;
    return clamp_period(np);
  endfunction

  function automatic void ramp_reset();
    m_time_scale = 785398; m_freq_scale = 1690; m_accel_scale = 628318530;
    m_phase = PH_STOP; m_period = 0; m_min_period = 0;
    m_index = 0; m_rem = 0; m_drive = 0;
  endfunction

  function automatic ramp_out_t ramp_predict(cmd_e cmd, logic [15:0] spd, logic [15:0] acc);
    ramp_out_t o;
    int n;
    logic [PB-1:0] np;
    o = '0;
    case (cmd)
      CMD_TICK: begin
        o.period = m_period;
        case (m_phase)
          PH_ACCEL: begin
            n = $signed(m_index);
            if (n < 32767) n++;
            m_index = n[15:0];
            np = recur_period();
            if (np <= m_min_period) begin
              np = m_min_period; m_rem = 0; m_phase = PH_RUN;
            end
            m_period = np; o.step = 1;
          end
          PH_RUN: begin
            m_period = m_min_period; o.step = 1;
          end
          PH_DECEL: begin
            n = $signed(m_index);
            if (n < 32767) n++;
            m_index = n[15:0];
            m_period = recur_period();
            if (n >= 0) m_phase = PH_STOP;
            o.step = 1;
          end
          default: begin
            m_rem = 0; m_drive = 0;
          end
        endcase
      end
      CMD_SPEED: begin
        m_min_period = (spd == 0) ? PMAX[PB-1:0] : clamp_period(64'(m_time_scale) / spd);
        if (m_phase == PH_STOP) begin
          if (acc == 0) m_period = PMAX[PB-1:0];
          else m_period = clamp_period(64'(m_freq_scale) *
                                       root_rounded(m_accel_scale / acc) / 100);
        end
        if (m_period <= m_min_period) begin
          m_period = m_min_period; m_phase = PH_RUN;
        end else m_phase = PH_ACCEL;
        m_index = 0; m_drive = 1;
        o.period = m_period;
      end
      CMD_STOP: begin
        if (m_phase == PH_ACCEL || m_phase == PH_RUN) begin
          m_index = -m_index; m_phase = PH_DECEL;
        end
        o.period = m_period;
      end
      default: o.period = m_period;
    endcase
    o.running = m_drive;
    o.phase = m_phase;
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // result side: random stall, compare each transaction against the oldest prediction
  always @(posedge clk_i) begin
    ramp_out_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[PB+3:0];
      if (pending_results.size() == 0) report_mismatch("unexpected result", 1, 0);
      else begin
        want = pending_results.pop_front();
        if (got.step !== want.step) report_mismatch("step", got.step, want.step);
        if (got.period !== want.period) report_mismatch("period_out", got.period, want.period);
        if (got.running !== want.running)
          report_mismatch("running", got.running, want.running);
        if (got.phase !== want.phase) report_mismatch("phase", got.phase, want.phase);
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall);
  end

  // send one command transaction, honoring the idle rate, predicting on acceptance
  task automatic send_cmd(cmd_e cmd, logic [15:0] spd, logic [15:0] acc);
    while ($urandom_range(99) < send_idle) @(posedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {acc, spd};
    s_axis_tuser <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(ramp_predict(cmd, spd, acc));
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  // register writes only when the unit is idle
  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    cfg_valid_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_TIME_SCALE: m_time_scale = val;
      CFG_FREQ_SCALE: m_freq_scale = val[15:0];
      default:        m_accel_scale = val;
    endcase
    @(posedge clk_i);
  endtask

  // directed stimulus; typed checks where the answer is obvious
  typedef struct {
    cmd_e cmd; logic [15:0] spd; logic [15:0] acc;
    bit typed; logic step; logic [15:0] per; logic run; phase_e ph;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    '{CMD_TICK,  16'h0000, 16'h0000, 1, 0, 16'd0, 0, PH_STOP},   // tick after reset
    '{CMD_STOP,  16'hFFFF, 16'hFFFF, 1, 0, 16'd0, 0, PH_STOP},   // stop ignored in stop
    '{CMD_NONE,  16'hFFFF, 16'hFFFF, 1, 0, 16'd0, 0, PH_STOP},   // unused command
    '{CMD_SPEED, 16'h0000, 16'h0000, 1, 0, 16'hFFFF, 1, PH_RUN}, // both divisors zero
    '{CMD_TICK,  16'h0000, 16'h0000, 1, 1, 16'hFFFF, 1, PH_RUN},
    '{CMD_STOP,  16'h0000, 16'h0000, 0, 0, 0, 0, PH_STOP},
    '{CMD_TICK,  16'h0000, 16'h0000, 0, 0, 0, 0, PH_STOP},
    '{CMD_TICK,  16'h0000, 16'h0000, 0, 0, 0, 0, PH_STOP},
    '{CMD_SPEED, 16'hFFFF, 16'h0001, 0, 0, 0, 0, PH_STOP},       // fast and gentle: accelerate
    '{CMD_TICK,  16'h0000, 16'h0000, 0, 0, 0, 0, PH_STOP},
    '{CMD_TICK,  16'h0000, 16'h0000, 0, 0, 0, 0, PH_STOP},
    '{CMD_TICK,  16'h0000, 16'h0000, 0, 0, 0, 0, PH_STOP},
    '{CMD_SPEED, 16'h0100, 16'hFFFF, 0, 0, 0, 0, PH_STOP},       // new speed while moving
    '{CMD_STOP,  16'h0000, 16'h0000, 0, 0, 0, 0, PH_STOP},       // mirror the ramp
    '{CMD_STOP,  16'h0000, 16'h0000, 0, 0, 0, 0, PH_STOP},       // ignored in decelerate
    '{CMD_TICK,  16'h0000, 16'h0000, 0, 0, 0, 0, PH_STOP},
    '{CMD_TICK,  16'h0000, 16'h0000, 0, 0, 0, 0, PH_STOP},
    '{CMD_TICK,  16'h0000, 16'h0000, 0, 0, 0, 0, PH_STOP},
    '{CMD_TICK,  16'h0000, 16'h0000, 0, 0, 0, 0, PH_STOP},
    '{CMD_TICK,  16'h0000, 16'h0000, 0, 0, 0, 0, PH_STOP},
    '{CMD_SPEED, 16'h0001, 16'hFFFF, 0, 0, 0, 0, PH_STOP}        // slowest speed
  };

  // one ramp with random content: set speed, ticks, optional new speed, stop, ticks down to stop, optional command
  task automatic random_ramp(output int sent);
    int k;
    sent = 0;
    send_cmd(CMD_SPEED, 16'($urandom_range(1, 2000)), 16'($urandom_range(1, 65535)));
    sent++;
    k = $urandom_range(0, 20);
    repeat (k) begin send_cmd(CMD_TICK, 16'($urandom), 16'($urandom)); sent++; end
    if ($urandom_range(3) == 0) begin
      send_cmd(CMD_SPEED, 16'($urandom), 16'($urandom)); sent++;
    end
    send_cmd(CMD_STOP, 16'($urandom), 16'($urandom)); sent++;
    repeat (k + $urandom_range(0, 4)) begin
      send_cmd(CMD_TICK, 16'($urandom), 16'($urandom)); sent++;
    end
    if ($urandom_range(4) == 0) begin
      send_cmd(cmd_e'($urandom_range(3)), 16'($urandom), 16'($urandom)); sent++;
    end
  endtask

  initial begin
    ramp_out_t want;
    ramp_out_t got_pred;
    int s, ph;
    ramp_reset();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_cmd(dir_rows[i].cmd, dir_rows[i].spd, dir_rows[i].acc);
      if (dir_rows[i].typed) begin
        got_pred = pending_results[$];
        want = '{step: dir_rows[i].step, period: dir_rows[i].per,
                 running: dir_rows[i].run, phase: dir_rows[i].ph};
        if (got_pred !== want) report_mismatch("directed row", i, i);
        pending_results[$] = want;
      end
    end
    // pause until every expected result has come
    drain();

    // register settings, extremes included, one per phase
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 73; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 73; end
        3: begin send_idle = 10; recv_stall = 10; end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      case (ph)
        0: begin
          write_reg(CFG_TIME_SCALE, 32'hFFFF_FFFF);
          write_reg(CFG_FREQ_SCALE, 32'h0000_FFFF);
          write_reg(CFG_ACCEL_SCALE, 32'hFFFF_FFFF);
        end
        1: begin
          write_reg(CFG_TIME_SCALE, 32'd0);
          write_reg(CFG_FREQ_SCALE, 32'd0);
          write_reg(CFG_ACCEL_SCALE, 32'd0);
        end
        2: begin
          write_reg(CFG_TIME_SCALE, $urandom);
          write_reg(CFG_FREQ_SCALE, $urandom);
          write_reg(CFG_ACCEL_SCALE, $urandom);
        end
        default: begin
          write_reg(CFG_TIME_SCALE, 32'd785398);
          write_reg(CFG_FREQ_SCALE, 32'd1690);
          write_reg(CFG_ACCEL_SCALE, 32'd628318530);
        end
      endcase
      for (int c = 0; c < 240; c += s) random_ramp(s);
      drain();
    end

    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #8000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[stepper_linear_speed_ramp_unit.f]
rtl/core/slsr_pkg.sv
rtl/core/slsr_dp.sv
rtl/core/slsr_ctrl.sv
rtl/core/stepper_linear_speed_ramp_unit.sv
tb/tb_stepper_linear_speed_ramp_unit.sv
